>>> sv/hts_pkg.sv
// -----------------------------------------------------------------------------
// hts_pkg
// Constants and pattern tables shared by the HTML tag stripper and its checker.
// -----------------------------------------------------------------------------
package hts_pkg;

	localparam int unsigned PatCount = 4;
	localparam int unsigned PatMaxLen = 8;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] offset_t;
	typedef logic [PatCount-1:0] alive_t;

	// pattern indexes (bit positions in the alive mask)
	localparam int unsigned PAT_SCRIPT = 0;
	localparam int unsigned PAT_STYLE = 1;
	localparam int unsigned PAT_END_SCRIPT = 2;
	localparam int unsigned PAT_END_STYLE = 3;

	localparam byte_t CHAR_LT = 8'h3C;
	localparam byte_t CHAR_GT = 8'h3E;
	localparam byte_t CHAR_UC_A = 8'h41;
	localparam byte_t CHAR_UC_Z = 8'h5A;
	localparam byte_t CASE_OFFSET = 8'h20;

	localparam byte_t PAT_TEXT [PatCount][PatMaxLen] = '{
		'{"s", "c", "r", "i", "p", "t", 8'h00, 8'h00},
		'{"s", "t", "y", "l", "e", 8'h00, 8'h00, 8'h00},
		'{"/", "s", "c", "r", "i", "p", "t", 8'h00},
		'{"/", "s", "t", "y", "l", "e", 8'h00, 8'h00}
	};

	localparam offset_t PAT_LEN [PatCount] = '{3'd6, 3'd5, 3'd7, 3'd6};

	function automatic byte_t fold_lower(input byte_t c);
		byte_t r;
		r = c;
		if (c inside {[CHAR_UC_A:CHAR_UC_Z]}) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

>>> sv/html_tag_stripper_core.sv
// -----------------------------------------------------------------------------
// html_tag_stripper_core
// Passes on text bytes outside tags and outside script and style regions; other
// beats leave with keep low and a zero byte. Beats go through an input stage and
// a result register. Throughput: one beat per cycle unless stalled; tag and
// region state advance as a beat leaves the input stage, so back-to-back bytes
// see each other's updates. Reset: arst_n clears tag, region and match state and
// both valid flags.
module html_tag_stripper_core
	import hts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] html_byte
	input  logic       s_axis_tuser,   // [0] first_of_text
	input  logic       s_axis_tlast,   // last_of_text
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] text_byte
	output logic       m_axis_tuser,   // [0] keep
	output logic       m_axis_tlast    // end_of_text
);

	logic    valid_s1;
	byte_t   byte_s1;
	logic    first_s1;
	logic    last_s1;
	logic    adv_s1;

	logic    tag_q;
	logic    script_q;
	logic    style_q;
	offset_t off_q;
	alive_t  alive_q;

	logic    tag_d;
	logic    script_d;
	logic    style_d;
	offset_t off_d;
	alive_t  alive_d;
	logic    keep_d;

	assign adv_s1 = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			first_s1 <= s_axis_tuser;
			last_s1  <= s_axis_tlast;
		end
	end

	always_comb begin
		byte_t  lc;
		alive_t alive_in;
		offset_t off_in;
		logic   hit;
		tag_d    = tag_q;
		script_d = script_q;
		style_d  = style_q;
		off_in   = off_q;
		alive_in = alive_q;
		keep_d   = 1'b0;
		hit      = 1'b0;
		lc       = fold_lower(byte_s1);
		if (first_s1) begin
			tag_d    = 1'b0;
			script_d = 1'b0;
			style_d  = 1'b0;
			off_in   = '0;
			alive_in = '0;
		end
		off_d   = off_in;
		alive_d = alive_in;
		if (byte_s1 == CHAR_LT) begin
			tag_d   = 1'b1;
			off_d   = '0;
			alive_d = '1;
		end else if (byte_s1 == CHAR_GT) begin
			tag_d   = 1'b0;
			off_d   = '0;
			alive_d = '0;
		end else begin
			if (alive_in != '0) begin
				for (int p = 0; p < PatCount; p++) begin
					hit = (off_in < PAT_LEN[p]) && (PAT_TEXT[p][off_in] == lc);
					if (alive_in[p] && !hit) begin
						alive_d[p] = 1'b0;
					end else if (alive_in[p] && (off_in + 3'd1 == PAT_LEN[p])) begin
						alive_d[p] = 1'b0;
						case (p)
							PAT_SCRIPT:     script_d = 1'b1;
							PAT_STYLE:      style_d  = 1'b1;
							PAT_END_SCRIPT: script_d = 1'b0;
							PAT_END_STYLE:  style_d  = 1'b0;
							default:        ;
						endcase
					end
				end
				off_d = (alive_d == '0) ? '0 : off_in + 3'd1;
			end
			keep_d = !tag_d && !script_d && !style_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q    <= 1'b0;
			script_q <= 1'b0;
			style_q  <= 1'b0;
			off_q    <= '0;
			alive_q  <= '0;
		end else if (valid_s1 && adv_s1) begin
			tag_q    <= tag_d;
			script_q <= script_d;
			style_q  <= style_d;
			off_q    <= off_d;
			alive_q  <= alive_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv_s1) begin
			m_axis_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			m_axis_tdata <= keep_d ? byte_s1 : '0;
			m_axis_tuser <= keep_d;
			m_axis_tlast <= last_s1;
		end
	end

endmodule

>>> sv/hts_checker.sv
// -----------------------------------------------------------------------------
// hts_checker
// Port-level checks for the HTML tag stripper, bound to the top level.
// -----------------------------------------------------------------------------
module hts_checker
	import hts_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tuser,
	input logic       m_axis_tlast
);

	// dropped beats carry a zero byte
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'h00))
		else $error("dropped beat with non-zero data");

	// tag delimiters never pass through
	a_no_delim: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
			(m_axis_tdata != CHAR_LT && m_axis_tdata != CHAR_GT))
		else $error("tag delimiter kept");

	// input only stalls behind a waiting result beat
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled with no waiting result beat");

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			 && $stable(m_axis_tlast)))
		else $error("stalled result beat changed");

endmodule

bind html_tag_stripper_core hts_checker u_hts_checker (.*);
